>>> hdl/vtbt_pkg.sv
// Shared types and constants of the volume table block translator.
// Used by the core, the entry calculator and the port checker; no dependencies.
`default_nettype none

package vtbt_pkg;

  // Fixed field widths of the command and result words.
  localparam int OP_W     = 2;
  localparam int CYL_W    = 4;
  localparam int SEC_W    = 4;
  localparam int SIZE_W   = 17;
  localparam int VIDX_W   = 3;
  localparam int BLK_W    = 8;
  localparam int STATUS_W = 3;
  localparam int RCYL_W   = 5;
  localparam int TOTAL_W  = 4;

  // Disk geometry.
  localparam int SECTORS_PER_CYLINDER = 16;
  localparam int CYLINDER_COUNT       = 16;
  localparam int SECTOR_BYTES         = 256;
  localparam int MAX_SIZE_BYTES       = 65536;

  // Derived widths.
  localparam int LEN_W  = $clog2(MAX_SIZE_BYTES / SECTOR_BYTES + 1);
  localparam int LIN_W  = CYL_W + $clog2(SECTORS_PER_CYLINDER);
  localparam int SPAN_W = ((LIN_W > LEN_W) ? LIN_W : LEN_W) + 1;
  localparam int SUM_W  = BLK_W + 1;

  // Command codes.
  localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE    = 2'd1;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOVOL   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd5;

  // One volume table entry as held in the entry memory.
  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic [SEC_W-1:0] sector;
    logic [LEN_W-1:0] length;
  } entry_t;

  // What the calculator derives from one entry and the current command.
  typedef struct packed {
    logic              overlap;
    logic              in_range;
    logic [RCYL_W-1:0] cylinder;
    logic [SEC_W-1:0]  sector;
  } calc_t;

endpackage

`default_nettype wire

>>> hdl/vtbt_calc.sv
// Entry calculator: overlap test for an add and address mapping for a translate.
// Depends on vtbt_pkg.
`default_nettype none

module vtbt_calc (
  input  vtbt_pkg::entry_t                  entry,
  input  logic [vtbt_pkg::CYL_W-1:0]        start_cylinder,
  input  logic [vtbt_pkg::SEC_W-1:0]        start_sector,
  input  logic [vtbt_pkg::BLK_W-1:0]        block_number,
  output vtbt_pkg::calc_t                   calc
);

  logic [vtbt_pkg::LIN_W-1:0] first_lin;
  logic [vtbt_pkg::LIN_W-1:0] start_lin;
  logic [vtbt_pkg::SUM_W-1:0] sum;

  // Linear sector numbers of the entry start and of the new volume start.
  assign first_lin = vtbt_pkg::LIN_W'(entry.cylinder)
                   * vtbt_pkg::LIN_W'(vtbt_pkg::SECTORS_PER_CYLINDER)
                   + vtbt_pkg::LIN_W'(entry.sector);
  assign start_lin = vtbt_pkg::LIN_W'(start_cylinder)
                   * vtbt_pkg::LIN_W'(vtbt_pkg::SECTORS_PER_CYLINDER)
                   + vtbt_pkg::LIN_W'(start_sector);

  // The new start overlaps when it lies in [first, first + length).
  assign calc.overlap = (start_lin >= first_lin) &&
                        (vtbt_pkg::SPAN_W'(start_lin) <
                         vtbt_pkg::SPAN_W'(first_lin) + vtbt_pkg::SPAN_W'(entry.length));

  // Translation of a block inside the volume.
  assign calc.in_range = vtbt_pkg::LEN_W'(block_number) < entry.length;
  assign sum           = vtbt_pkg::SUM_W'(entry.sector) + vtbt_pkg::SUM_W'(block_number);
  assign calc.cylinder = vtbt_pkg::RCYL_W'(entry.cylinder)
                       + vtbt_pkg::RCYL_W'(sum / vtbt_pkg::SECTORS_PER_CYLINDER);
  assign calc.sector   = vtbt_pkg::SEC_W'(sum % vtbt_pkg::SECTORS_PER_CYLINDER);

endmodule

`default_nettype wire

>>> hdl/volume_table_block_translator_core.sv
// Top level of the volume table block translator: sequencer and entry memory.
// Depends on vtbt_pkg and vtbt_calc.
`default_nettype none

// The block holds a table of up to MAX_VOLUMES volumes in a small synchronous
// memory and executes one command word at a time, returning one result word per
// command. All entries are read through one memory port with registered read
// data, which sets the timing. A command that is rejected at once or has no
// effect goes from idle to the done state, which loads the result word into
// the output register. A translate reads its entry, then maps the block. An
// add that appends reads and compares each volume in the table, then writes
// the new entry; an add that hits an overlap stops at that entry. A remove
// reads and writes back each entry that moves down. A finished result sits
// in the output register, and the next command word is taken while it waits
// to be read. That next command holds in its done state until the word is read.
module volume_table_block_translator_core #(
  parameter int MAX_VOLUMES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [vtbt_pkg::OP_W-1:0]         opcode,
  input  logic [vtbt_pkg::CYL_W-1:0]        start_cylinder,
  input  logic [vtbt_pkg::SEC_W-1:0]        start_sector,
  input  logic [vtbt_pkg::SIZE_W-1:0]       size_bytes,
  input  logic [vtbt_pkg::VIDX_W-1:0]       volume_index,
  input  logic [vtbt_pkg::BLK_W-1:0]        block_number,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [vtbt_pkg::STATUS_W-1:0]     status,
  output logic [vtbt_pkg::RCYL_W-1:0]       result_cylinder,
  output logic [vtbt_pkg::SEC_W-1:0]        result_sector,
  output logic [vtbt_pkg::TOTAL_W-1:0]      volume_total
);

  localparam int CNT_W = $clog2(MAX_VOLUMES + 1);
  localparam int AW    = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
  localparam int IW    = (CNT_W > vtbt_pkg::VIDX_W) ? CNT_W : vtbt_pkg::VIDX_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_XLATE    = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]                    state, state_next;
  logic [CNT_W-1:0]              count, count_next;
  logic [CNT_W-1:0]              k, k_next;
  logic [vtbt_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [vtbt_pkg::RCYL_W-1:0]   res_cyl, res_cyl_next;
  logic [vtbt_pkg::SEC_W-1:0]    res_sec, res_sec_next;
  logic                          load_out;

  // Captured command word.
  logic [vtbt_pkg::CYL_W-1:0]    cyl_r;
  logic [vtbt_pkg::SEC_W-1:0]    sec_r;
  logic [vtbt_pkg::SIZE_W-1:0]   size_r;
  logic [vtbt_pkg::BLK_W-1:0]    blk_r;

  // Entry memory and its port.
  vtbt_pkg::entry_t              mem [MAX_VOLUMES];
  vtbt_pkg::entry_t              rd_entry;
  vtbt_pkg::entry_t              new_entry;
  vtbt_pkg::entry_t              mem_wdata;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [AW-1:0]                 mem_raddr;

  vtbt_pkg::calc_t               calc;
  logic                          add_bad;
  logic                          idx_missing;
  logic [vtbt_pkg::SIZE_W:0]     len_sum;

  assign in_ready = (state == S_IDLE);

  // Position and size checks of an add, taken straight from the command word.
  assign add_bad = (32'(start_cylinder) >= vtbt_pkg::CYLINDER_COUNT) ||
                   (32'(start_sector) >= vtbt_pkg::SECTORS_PER_CYLINDER) ||
                   (size_bytes == '0) ||
                   (32'(size_bytes) > vtbt_pkg::MAX_SIZE_BYTES);
  assign idx_missing = IW'(volume_index) >= IW'(count);

  // Length in sectors, rounded up.
  assign len_sum = (vtbt_pkg::SIZE_W + 1)'(size_r)
                 + (vtbt_pkg::SIZE_W + 1)'(vtbt_pkg::SECTOR_BYTES - 1);
  assign new_entry.cylinder = cyl_r;
  assign new_entry.sector   = sec_r;
  assign new_entry.length   = vtbt_pkg::LEN_W'(len_sum / vtbt_pkg::SECTOR_BYTES);

  vtbt_calc u_calc (
    .entry          (rd_entry),
    .start_cylinder (cyl_r),
    .start_sector   (sec_r),
    .block_number   (blk_r),
    .calc           (calc)
  );

  // Command sequencer.
  always_comb begin
    state_next      = state;
    count_next      = count;
    k_next          = k;
    res_status_next = res_status;
    res_cyl_next    = res_cyl;
    res_sec_next    = res_sec;
    load_out        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = new_entry;
    mem_raddr       = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = vtbt_pkg::ST_OK;
          res_cyl_next    = '0;
          res_sec_next    = '0;
          k_next          = '0;
          state_next      = S_DONE;
          case (opcode)
            vtbt_pkg::OP_ADD: begin
              if (add_bad) begin
                res_status_next = vtbt_pkg::ST_BAD;
              end else if (count >= CNT_W'(MAX_VOLUMES)) begin
                res_status_next = vtbt_pkg::ST_FULL;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
            vtbt_pkg::OP_REMOVE: begin
              if (idx_missing) begin
                res_status_next = vtbt_pkg::ST_NOVOL;
              end else begin
                k_next     = CNT_W'(volume_index);
                state_next = S_SHIFT_RD;
              end
            end
            vtbt_pkg::OP_TRANSLATE: begin
              if (idx_missing) begin
                res_status_next = vtbt_pkg::ST_NOVOL;
              end else begin
                mem_raddr  = AW'(volume_index);
                state_next = S_XLATE;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (k == count) begin
          // No overlap anywhere: append the entry.
          mem_we     = 1'b1;
          mem_waddr  = count[AW-1:0];
          count_next = count + CNT_W'(1);
          state_next = S_DONE;
        end else begin
          mem_raddr  = k[AW-1:0];
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (calc.overlap) begin
          res_status_next = vtbt_pkg::ST_OVERLAP;
          state_next      = S_DONE;
        end else begin
          k_next     = k + CNT_W'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if ((k + CNT_W'(1)) < count) begin
          mem_raddr  = AW'(k + CNT_W'(1));
          state_next = S_SHIFT_WR;
        end else begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = k[AW-1:0];
        mem_wdata  = rd_entry;
        k_next     = k + CNT_W'(1);
        state_next = S_SHIFT_RD;
      end
      S_XLATE: begin
        if (!calc.in_range) begin
          res_status_next = vtbt_pkg::ST_RANGE;
        end else begin
          res_cyl_next = calc.cylinder;
          res_sec_next = calc.sector;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    k          <= k_next;
    res_status <= res_status_next;
    res_cyl    <= res_cyl_next;
    res_sec    <= res_sec_next;
    if (in_valid && in_ready) begin
      cyl_r  <= start_cylinder;
      sec_r  <= start_sector;
      size_r <= size_bytes;
      blk_r  <= block_number;
    end
    if (load_out) begin
      status          <= res_status;
      result_cylinder <= res_cyl;
      result_sector   <= res_sec;
      volume_total    <= vtbt_pkg::TOTAL_W'(count);
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= mem[mem_raddr];
  end

endmodule

`default_nettype wire

>>> hdl/vtbt_checker.sv
// Port-level checker of the volume table block translator, with its bind.
// Depends on vtbt_pkg and on the ports of volume_table_block_translator_core.
`default_nettype none

module vtbt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [vtbt_pkg::STATUS_W-1:0]     status,
  input logic [vtbt_pkg::RCYL_W-1:0]       result_cylinder,
  input logic [vtbt_pkg::SEC_W-1:0]        result_sector,
  input logic [vtbt_pkg::TOTAL_W-1:0]      volume_total
);

  logic [1:0]                       pend;
  logic [vtbt_pkg::TOTAL_W-1:0]     last_total;
  logic                             in_acc;
  logic                             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted but not yet delivered, and the last delivered volume count.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= '0;
      last_total <= '0;
    end else begin
      pend <= pend + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        last_total <= volume_total;
      end
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(volume_total))
    else $error("result word changed while stalled");

  // Every result word belongs to an accepted command, and at most two are in flight.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (out_valid |-> pend != 2'd0) and (pend != 2'd3))
    else $error("result word without a pending command");

  // A failed command leaves the table size unchanged.
  a_fail_keeps_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != vtbt_pkg::ST_OK |-> volume_total == last_total)
    else $error("failed command changed the volume count");

  // A failed command reports no address.
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != vtbt_pkg::ST_OK |-> result_cylinder == '0 && result_sector == '0)
    else $error("failed command reported an address");

endmodule

bind volume_table_block_translator_core vtbt_checker u_vtbt_checker (.*);

`default_nettype wire
